// File: rtl/core/wcba_pkg.sv
// Shared types, constants and the power level table of the wheel current budget allocator.
package wcba_pkg;

   localparam int unsigned WCBA_QUEUE_DEPTH = 4;
   localparam int unsigned WHEELS           = 4;

   // Drive mode codes
   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_FLY    = 2'd1;
   localparam logic [1:0] MODE_SHIFT  = 2'd2;
   localparam logic [1:0] MODE_CLIMB  = 2'd3;

   // Budget limits in current units
   localparam logic [15:0] BUDGET_MAX       = 16'd32000;
   localparam logic [15:0] BUDGET_MIN       = 16'd5000;
   localparam logic [15:0] CLIMB_FLOOR      = 16'd18000;
   localparam logic [15:0] DEFAULT_BUDGET   = 16'd12000;
   localparam logic [14:0] LOW_CHARGE_CAP   = 15'd6000;
   localparam logic [14:0] EMPTY_CHARGE_CAP = 15'd3000;

   // Charge thresholds in percent
   localparam logic signed [7:0] CHARGE_SCALE_LIMIT = 8'sd50;
   localparam logic signed [7:0] CHARGE_LOW_LIMIT   = 8'sd25;
   localparam logic signed [8:0] CHARGE_OFFSET      = 9'sd50;

   // floor(x / 25) == (x * RECIP_25) >> RECIP_SHIFT for every x below 2^20
   localparam logic [21:0] RECIP_25    = 22'd2684355;
   localparam int unsigned RECIP_SHIFT = 26;

   // Share divider: 15 quotient bits, 3 per iteration
   localparam int unsigned QUOT_W    = 15;
   localparam int unsigned DIV_STEPS = 3;
   localparam int unsigned DIV_ITERS = QUOT_W / DIV_STEPS;

   typedef struct packed {
      logic [1:0]         drive_mode;
      logic [7:0]         power_level;
      logic signed [7:0]  charge_percent;
      logic signed [15:0] demand_lf;
      logic signed [15:0] demand_rf;
      logic signed [15:0] demand_lb;
      logic signed [15:0] demand_rb;
   } req_type;

   typedef struct packed {
      logic [14:0] limit_lf;
      logic [14:0] limit_rf;
      logic [14:0] limit_lb;
      logic [14:0] limit_rb;
   } rsp_type;

   // One classified item waiting for the share divider
   typedef struct packed {
      logic [14:0]                   budget;
      logic [WHEELS-1:0][16:0]       mag;
      logic [17:0]                   sum;
      logic                          sum_small;
   } work_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_MUL,
      BACK_DIV
   } back_state_type;

   function automatic logic [15:0] table_budget(input logic [7:0] level);
      logic [15:0] b;
      case (level)
         8'd45:   b = 16'd12000;
         8'd50:   b = 16'd12800;
         8'd55:   b = 16'd14000;
         8'd60:   b = 16'd15200;
         8'd70:   b = 16'd16800;
         8'd80:   b = 16'd18800;
         8'd100:  b = 16'd21200;
         8'd120:  b = 16'd22000;
         default: b = DEFAULT_BUDGET;
      endcase
      return b;
   endfunction

endpackage

// File: rtl/core/wcba_front.sv
// Front end: accept a transaction, take demand magnitudes and derive the total budget.
module wcba_front
   import wcba_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     accept,
   input  req_type  req,
   output logic     push,
   output work_type push_data,
   output logic [1:0] inflight
);

   // Stage 1: base budget, scale factor, magnitudes
   logic        s1_valid_ff, s1_valid_in;
   logic [15:0] s1_base_ff, s1_base_in;
   logic [6:0]  s1_factor_ff, s1_factor_in;
   logic        s1_scale_ff, s1_scale_in;
   logic        s1_zero_ff, s1_zero_in;
   logic        s1_low_ff, s1_low_in;
   logic        s1_neg_ff, s1_neg_in;
   work_type    s1_work_ff, s1_work_in;

   // Stage 2: budget times factor
   logic        s2_valid_ff;
   logic [21:0] s2_prod_ff, s2_prod_in;
   logic        s2_scale_ff, s2_zero_ff, s2_low_ff, s2_neg_ff;
   work_type    s2_work_ff;

   // Stage 3: divided by one hundred
   logic        s3_valid_ff;
   logic [15:0] s3_quo_ff, s3_quo_in;
   logic        s3_zero_ff, s3_low_ff, s3_neg_ff;
   work_type    s3_work_ff;

   logic [15:0] tbl;
   logic signed [8:0] factor;
   logic [WHEELS-1:0][15:0] demand;
   logic [41:0] recip_prod;
   logic [15:0] raw_budget;
   logic [15:0] clamped;
   logic [14:0] capped;

   assign s1_valid_in = accept;
   assign tbl         = table_budget(req.power_level);
   assign factor      = {req.charge_percent[7], req.charge_percent} + CHARGE_OFFSET;
   assign demand      = {req.demand_rb, req.demand_lb, req.demand_rf, req.demand_lf};

   always_comb begin
      logic [16:0] ext;
      logic [17:0] total;
      case (req.drive_mode)
         MODE_FLY:   s1_base_in = BUDGET_MAX;
         MODE_SHIFT: s1_base_in = tbl + {1'b0, tbl[15:1]};
         MODE_CLIMB: s1_base_in = (tbl < CLIMB_FLOOR) ? CLIMB_FLOOR : tbl;
         default:    s1_base_in = tbl;
      endcase
      s1_scale_in  = (req.drive_mode != MODE_FLY) &&
                     (req.charge_percent < CHARGE_SCALE_LIMIT);
      s1_zero_in   = s1_scale_in && (factor <= 9'sd0);
      s1_factor_in = factor[6:0];
      s1_low_in    = req.charge_percent < CHARGE_LOW_LIMIT;
      s1_neg_in    = req.charge_percent[7];

      total = '0;
      s1_work_in = '0;
      for (int w = 0; w < WHEELS; w++) begin
         ext = {demand[w][15], demand[w]};
         s1_work_in.mag[w] = demand[w][15] ? (~ext + 17'd1) : ext;
         total = total + {1'b0, s1_work_in.mag[w]};
      end
      s1_work_in.sum       = total;
      s1_work_in.sum_small = total <= 18'd1;
   end

   assign s2_prod_in = s1_scale_ff ? ({6'b0, s1_base_ff} * {15'b0, s1_factor_ff})
                                   : {6'b0, s1_base_ff};

   assign recip_prod = {22'b0, s2_prod_ff[21:2]} * {20'b0, RECIP_25};
   assign s3_quo_in  = s2_scale_ff ? recip_prod[RECIP_SHIFT +: 16] : s2_prod_ff[15:0];

   // Clamp to the budget window, then apply the charge caps
   always_comb begin
      raw_budget = s3_zero_ff ? 16'd0 : s3_quo_ff;
      if (raw_budget < BUDGET_MIN) begin
         clamped = BUDGET_MIN;
      end else if (raw_budget > BUDGET_MAX) begin
         clamped = BUDGET_MAX;
      end else begin
         clamped = raw_budget;
      end
      capped = clamped[14:0];
      if (s3_low_ff && (capped > LOW_CHARGE_CAP)) begin
         capped = LOW_CHARGE_CAP;
      end
      if (s3_neg_ff && (capped > EMPTY_CHARGE_CAP)) begin
         capped = EMPTY_CHARGE_CAP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_base_ff   <= s1_base_in;
      s1_factor_ff <= s1_factor_in;
      s1_scale_ff  <= s1_scale_in;
      s1_zero_ff   <= s1_zero_in;
      s1_low_ff    <= s1_low_in;
      s1_neg_ff    <= s1_neg_in;
      s1_work_ff   <= s1_work_in;

      s2_prod_ff   <= s2_prod_in;
      s2_scale_ff  <= s1_scale_ff;
      s2_zero_ff   <= s1_zero_ff;
      s2_low_ff    <= s1_low_ff;
      s2_neg_ff    <= s1_neg_ff;
      s2_work_ff   <= s1_work_ff;

      s3_quo_ff    <= s3_quo_in;
      s3_zero_ff   <= s2_zero_ff;
      s3_low_ff    <= s2_low_ff;
      s3_neg_ff    <= s2_neg_ff;
      s3_work_ff   <= s2_work_ff;
   end

   always_comb begin
      push_data        = s3_work_ff;
      push_data.budget = capped;
   end

   assign push     = s3_valid_ff;
   assign inflight = {1'b0, s1_valid_ff} + {1'b0, s2_valid_ff} + {1'b0, s3_valid_ff};

endmodule

// File: rtl/core/wcba_queue.sv
// Short queue of classified items between the front end and the share divider.
module wcba_queue
   import wcba_pkg::*;
#(
   parameter int unsigned DEPTH = WCBA_QUEUE_DEPTH
)(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  work_type                   push_data,
   input  logic                       pop,
   output work_type                   head,
   output logic                       not_empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH+1);

   work_type             entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
   assign rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = count_ff != '0;
   assign count     = count_ff;

endmodule

// File: rtl/core/wcba_back.sv
// Back end: split the budget over four wheels with a three-bit-per-cycle divider.
module wcba_back
   import wcba_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     not_empty,
   input  work_type head,
   output logic     pop,
   output logic     rsp_valid,
   output rsp_type  rsp_payload
);

   localparam int unsigned ITER_W = $clog2(DIV_ITERS);

   back_state_type state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              last_iter;
   logic              load_mul;
   logic              div_step;
   logic              finish;

   work_type                       work_ff;
   logic [WHEELS-1:0][16:0]        rem_ff, rem_in;
   logic [WHEELS-1:0][QUOT_W-1:0]  dq_ff, dq_in;
   logic [WHEELS-1:0][31:0]        prod;
   logic [WHEELS-1:0][14:0]        share;

   logic    rsp_valid_ff;
   rsp_type rsp_payload_ff, rsp_payload_in;

   assign last_iter = iter_ff == ITER_W'(DIV_ITERS - 1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: if (not_empty) state_in = BACK_MUL;
         BACK_MUL:  state_in = BACK_DIV;
         BACK_DIV:  if (last_iter) state_in = BACK_IDLE;
         default:   state_in = BACK_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      pop      = 1'b0;
      load_mul = 1'b0;
      div_step = 1'b0;
      finish   = 1'b0;
      case (state_ff)
         BACK_IDLE: pop = not_empty;
         BACK_MUL:  load_mul = 1'b1;
         BACK_DIV: begin
            div_step = 1'b1;
            finish   = last_iter;
         end
         default: ;
      endcase
   end

   assign iter_in = load_mul ? '0 : (div_step ? iter_ff + ITER_W'(1) : iter_ff);

   // Restoring division, three quotient bits per lane each cycle
   always_comb begin
      logic [16:0]       r;
      logic [QUOT_W-1:0] q;
      logic [17:0]       t;
      logic              ge;
      for (int w = 0; w < WHEELS; w++) begin
         prod[w] = {17'b0, work_ff.budget} * {15'b0, work_ff.mag[w]};
         r = rem_ff[w];
         q = dq_ff[w];
         for (int s = 0; s < DIV_STEPS; s++) begin
            t  = {r, q[QUOT_W-1]};
            ge = t >= work_ff.sum;
            q  = {q[QUOT_W-2:0], ge};
            r  = ge ? 17'(t - work_ff.sum) : t[16:0];
         end
         rem_in[w] = r;
         dq_in[w]  = q;
         share[w]  = work_ff.sum_small ? work_ff.budget : q;
      end
   end

   assign rsp_payload_in = '{limit_lf: share[0], limit_rf: share[1],
                             limit_lb: share[2], limit_rb: share[3]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= finish;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         work_ff <= head;
      end
      if (load_mul) begin
         for (int w = 0; w < WHEELS; w++) begin
            rem_ff[w] <= prod[w][31:QUOT_W];
            dq_ff[w]  <= prod[w][QUOT_W-1:0];
         end
      end else if (div_step) begin
         rem_ff <= rem_in;
         dq_ff  <= dq_in;
      end
      if (finish) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// File: rtl/core/wheel_current_budget_allocator.sv
// Top level of the wheel current budget allocator: front end, queue and share divider.
//
// Use: drive req_payload and raise start; the transaction is taken at the rising edge
// where start is high and busy is low. Each transaction yields one result: the four
// wheel ceilings appear on rsp_payload for exactly one cycle with rsp_valid high.
// The receiver cannot hold results off, so take them in the cycle they are shown.
//
// With the queue empty, a taken transaction passes two more front stages, the queue
// write, the pop and the multiply, then five divider steps, the last of which also
// loads the output register that raises rsp_valid.
// Throughput: the front end takes one transaction per cycle while queue credit
// remains; the back end works on one item at a time, its pace set by the shared
// four-lane divider that retires three quotient bits per lane per cycle.
// busy rises when the queue plus the items still in the front stages fill
// QUEUE_DEPTH entries.
//
// Reset is synchronous and active high: it empties the queue and pipeline, holds
// busy high while asserted and leaves no result pending.
module wheel_current_budget_allocator
   import wcba_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = WCBA_QUEUE_DEPTH  // two or more entries
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_valid,
   output rsp_type rsp_payload
);

   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH+1);

   logic             accept;
   logic             push;
   work_type         push_data;
   logic [1:0]       inflight;
   logic             pop;
   work_type         head;
   logic             not_empty;
   logic [CNT_W-1:0] q_count;
   logic [CNT_W:0]   occupied;

   // Count queue entries plus items that will still land there
   assign occupied = {1'b0, q_count} + (CNT_W+1)'(inflight);
   assign busy     = reset || (occupied >= (CNT_W+1)'(QUEUE_DEPTH));
   assign accept   = start && !busy;

   // Classify the transaction and work out the total budget
   wcba_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_payload),
      .push      (push),
      .push_data (push_data),
      .inflight  (inflight)
   );

   // Hold classified items until the divider is free
   wcba_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .count     (q_count)
   );

   // Split the budget over the wheels and present the result
   wcba_back u_back (
      .clock       (clock),
      .reset       (reset),
      .not_empty   (not_empty),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   // Credit accounting must never overfill the queue
   assert property (@(posedge clock) disable iff (reset)
      q_count <= CNT_W'(QUEUE_DEPTH))
      else $error("queue holds more entries than its depth");

   // Results are spaced by the divider, never on consecutive cycles
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // A share never exceeds the largest budget
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.limit_lf <= 15'd32000) && (rsp_payload.limit_rf <= 15'd32000)
                 && (rsp_payload.limit_lb <= 15'd32000) && (rsp_payload.limit_rb <= 15'd32000))
      else $error("wheel ceiling above the budget maximum");
`endif

endmodule

// File: tb/tb.sv
// Self-checking testbench for the wheel current budget allocator.
module tb;
   import wcba_pkg::*;

   localparam int unsigned STALL_LIMIT   = 4000;  // cycles with no transaction at all
   localparam int unsigned RANDOM_ITEMS  = 1950;
   localparam int unsigned CALM_TAIL     = 150;   // last items go out without idling
   localparam int unsigned DRAIN_CYCLES  = 40;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_payload = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_payload;

   req_type     pending_items[$];      // stimulus not yet offered to the block
   rsp_type     ceilings_expected[$];  // predicted ceilings, oldest first
   int unsigned items_total    = 0;
   int unsigned items_accepted = 0;
   int unsigned mismatches     = 0;
   int unsigned stall_cycles   = 0;
   int unsigned idle_left      = 0;
   int unsigned idle_rate      = 0;    // percent chance of opening an idle burst
   logic        timed_out      = 1'b0;

   wheel_current_budget_allocator DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Work out the four wheel ceilings that one transaction must produce.
   function automatic rsp_type predict_ceilings(input req_type item);
      int unsigned       budget;
      int                charge;
      int                scale;
      int                demand[4];
      longint unsigned   mag[4];
      longint unsigned   total;
      longint unsigned   share[4];
      rsp_type           ceilings;
      charge    = item.charge_percent;
      demand[0] = item.demand_lf;
      demand[1] = item.demand_rf;
      demand[2] = item.demand_lb;
      demand[3] = item.demand_rb;
      total     = 0;
      for (int w = 0; w < 4; w++) begin
         // the most negative demand becomes 32768 here, no wrap
         mag[w] = (demand[w] < 0) ? longint'(-demand[w]) : longint'(demand[w]);
         total += mag[w];
      end

      if (item.drive_mode == MODE_FLY) begin
         budget = BUDGET_MAX;
      end else begin
         case (item.power_level)
            8'd45:   budget = 12000;
            8'd50:   budget = 12800;
            8'd55:   budget = 14000;
            8'd60:   budget = 15200;
            8'd70:   budget = 16800;
            8'd80:   budget = 18800;
            8'd100:  budget = 21200;
            8'd120:  budget = 22000;
            default: budget = DEFAULT_BUDGET;
         endcase
         if (item.drive_mode == MODE_SHIFT)
            budget = budget * 3 / 2;
         if (item.drive_mode == MODE_CLIMB && budget < CLIMB_FLOOR)
            budget = CLIMB_FLOOR;
         // a weak store scales the budget down, to nothing at or below -50 percent
         if (charge < CHARGE_SCALE_LIMIT) begin
            scale = charge + CHARGE_OFFSET;
            budget = (scale <= 0) ? 0 : budget * scale / 100;
         end
         if (budget < BUDGET_MIN) budget = BUDGET_MIN;
         if (budget > BUDGET_MAX) budget = BUDGET_MAX;
      end
      // the charge caps apply in fly mode as well
      if (charge < CHARGE_LOW_LIMIT && budget > LOW_CHARGE_CAP) budget = LOW_CHARGE_CAP;
      if (charge < 0 && budget > EMPTY_CHARGE_CAP) budget = EMPTY_CHARGE_CAP;

      for (int w = 0; w < 4; w++)
         share[w] = (total > 1) ? (longint'(budget) * mag[w]) / total : longint'(budget);
      ceilings.limit_lf = share[0][14:0];
      ceilings.limit_rf = share[1][14:0];
      ceilings.limit_lb = share[2][14:0];
      ceilings.limit_rb = share[3][14:0];
      return ceilings;
   endfunction

   task automatic add_item(input logic [1:0] mode, input int level, input int charge,
                           input int lf, input int rf, input int lb, input int rb);
      req_type item;
      item.drive_mode     = mode;
      item.power_level    = level[7:0];
      item.charge_percent = charge[7:0];
      item.demand_lf      = lf[15:0];
      item.demand_rf      = rf[15:0];
      item.demand_lb      = lb[15:0];
      item.demand_rb      = rb[15:0];
      pending_items.push_back(item);
   endtask

   // Draw one random demand; lean on zero, the extremes and small values now and then.
   function automatic int random_demand();
      int pick;
      pick = $urandom_range(0, 19);
      case (pick)
         0:       return 0;
         1:       return -32768;
         2:       return 32767;
         3, 4:    return int'($urandom_range(0, 200)) - 100;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   task automatic add_random_item();
      int listed[8];
      int level;
      int charge;
      int lf, rf, lb, rb;
      int pick;
      listed = '{45, 50, 55, 60, 70, 80, 100, 120};
      level  = ($urandom_range(0, 1) == 0) ? listed[$urandom_range(0, 7)]
                                           : int'($urandom_range(0, 255));
      // half the charges sit around the scale and cap thresholds
      charge = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 100)) - 52
                                           : int'($urandom_range(0, 255)) - 128;
      pick = $urandom_range(0, 11);
      if (pick == 0) begin
         // tiny total demand: at most one wheel asks for a single unit
         lf = 0; rf = 0; lb = 0; rb = 0;
         case ($urandom_range(0, 4))
            0: lf = ($urandom_range(0, 1) == 0) ? 1 : -1;
            1: rf = ($urandom_range(0, 1) == 0) ? 1 : -1;
            2: lb = ($urandom_range(0, 1) == 0) ? 1 : -1;
            3: rb = ($urandom_range(0, 1) == 0) ? 1 : -1;
            default: ;
         endcase
      end else begin
         lf = random_demand();
         rf = random_demand();
         lb = random_demand();
         rb = random_demand();
      end
      add_item(2'($urandom_range(0, 3)), level, charge, lf, rf, lb, rb);
   endtask

   task automatic report_mismatch(input string what, input int expected_v, input int actual_v);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch on %s: expected %0d, got %0d", what, expected_v, actual_v);
   endtask

   // Driver: offer queued transactions, hold each until taken, idle in random bursts.
   always @(posedge clock) begin
      logic offer_kept;
      offer_kept = 1'b0;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            ceilings_expected.push_back(predict_ceilings(req_payload));
            items_accepted++;
            // change the idling pace every hundred transactions, sometimes to none
            if (items_accepted % 100 == 0) begin
               case ($urandom_range(0, 2))
                  0:       idle_rate = 0;
                  1:       idle_rate = 6;
                  default: idle_rate = 25;
               endcase
            end
         end else if (start) begin
            offer_kept = 1'b1;  // hold the offer until busy drops
         end
         if (!offer_kept) begin
            if (idle_left > 0) begin
               idle_left--;
               start <= 1'b0;
            end else if (pending_items.size() == 0) begin
               start <= 1'b0;
            end else if (pending_items.size() > CALM_TAIL &&
                         $urandom_range(0, 99) < idle_rate) begin
               idle_left = $urandom_range(1, 18) - 1;
               start <= 1'b0;
            end else begin
               req_payload <= pending_items.pop_front();
               start       <= 1'b1;
            end
         end
      end
   end

   // Monitor: every strobed result is checked against the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (ceilings_expected.size() == 0) begin
            report_mismatch("unexpected result, limit_lf", -1, rsp_payload.limit_lf);
         end else begin
            want = ceilings_expected.pop_front();
            if (rsp_payload.limit_lf !== want.limit_lf)
               report_mismatch("limit_lf", want.limit_lf, rsp_payload.limit_lf);
            if (rsp_payload.limit_rf !== want.limit_rf)
               report_mismatch("limit_rf", want.limit_rf, rsp_payload.limit_rf);
            if (rsp_payload.limit_lb !== want.limit_lb)
               report_mismatch("limit_lb", want.limit_lb, rsp_payload.limit_lb);
            if (rsp_payload.limit_rb !== want.limit_rb)
               report_mismatch("limit_rb", want.limit_rb, rsp_payload.limit_rb);
         end
      end
   end

   // Count cycles in which neither side moves a transaction.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      // every mode from a plain table entry with a full store
      add_item(MODE_NORMAL, 45, 100, 1000, 2000, 3000, 4000);
      add_item(MODE_FLY,    45, 100, 1000, 2000, 3000, 4000);
      add_item(MODE_SHIFT,  45, 100, 1000, 2000, 3000, 4000);
      add_item(MODE_CLIMB,  45, 100, 1000, 2000, 3000, 4000);
      // remaining table entries, shift past the ceiling and climb above its floor
      add_item(MODE_NORMAL, 50, 127, 500, -500, 500, -500);
      add_item(MODE_SHIFT,  55, 60, 7, 11, 13, 17);
      add_item(MODE_CLIMB,  60, 75, -20000, 3, 0, 9000);
      add_item(MODE_NORMAL, 70, 50, 32767, 32767, 32767, 32767);
      add_item(MODE_CLIMB,  80, 90, 1, 1, 1, 1);
      add_item(MODE_SHIFT, 100, 99, 4, 0, 0, 0);
      add_item(MODE_SHIFT, 120, 127, -32768, -32768, -32768, -32768);
      // unlisted power levels fall back to the default entry
      add_item(MODE_NORMAL, 0, 80, 123, 456, 789, 1011);
      add_item(MODE_CLIMB, 255, 80, -32768, 32767, 0, 1);
      // charge around the scale, low and empty thresholds
      add_item(MODE_NORMAL, 120, 49, 100, 200, 300, 400);
      add_item(MODE_FLY,    120, 25, 100, 200, 300, 400);
      add_item(MODE_FLY,    120, 24, 100, 200, 300, 400);
      add_item(MODE_NORMAL, 100, 0, 100, 200, 300, 400);
      add_item(MODE_FLY,     45, -1, 100, 200, 300, 400);
      add_item(MODE_SHIFT,   45, -49, 100, 200, 300, 400);
      add_item(MODE_CLIMB,   45, -50, 100, 200, 300, 400);
      add_item(MODE_NORMAL,  45, -128, 100, 200, 300, 400);
      // tiny total demand hands the whole budget to every wheel
      add_item(MODE_NORMAL, 80, 100, 0, 0, 0, 0);
      add_item(MODE_FLY,    80, 100, 0, 0, -1, 0);
      add_item(MODE_SHIFT,  80, 100, 0, 1, 0, 0);
      for (int n = 0; n < RANDOM_ITEMS; n++)
         add_random_item();
      items_total = pending_items.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      fork
         begin
            while (items_accepted < items_total || ceilings_expected.size() != 0)
               @(posedge clock);
            // let any stray result show up before the verdict
            repeat (DRAIN_CYCLES) @(posedge clock);
         end
         begin
            while (stall_cycles < STALL_LIMIT) @(posedge clock);
            timed_out = 1'b1;
         end
      join_any

      if (!timed_out && mismatches == 0 && ceilings_expected.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: wheel_current_budget_allocator.f
rtl/core/wcba_pkg.sv
rtl/core/wcba_front.sv
rtl/core/wcba_queue.sv
rtl/core/wcba_back.sv
rtl/core/wheel_current_budget_allocator.sv
tb/tb.sv
